// File: src/mrr_pkg.sv
// shared constants and sequencer states for the miller-rabin round block
`default_nettype none
package mrr_pkg;

  localparam int CAND_W   = 32;  // candidate field width
  localparam int WIT_W    = 32;  // witness field width
  localparam int BITS_DEF = 32;  // default working width of n
  localparam int IN_W     = 64;  // input tdata width
  localparam int OUT_W    = 8;   // output tdata width

  typedef enum logic [3:0] {
    S_IDLE,
    S_STRIP,
    S_RED_GO,
    S_RED_WAIT,
    S_POW_CHK,
    S_PMUL_GO,
    S_PMUL_WAIT,
    S_PSQ_GO,
    S_PSQ_WAIT,
    S_CHECK,
    S_SQ_CHK,
    S_SQ_GO,
    S_SQ_WAIT,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

// File: src/mrr_modmul.sv
// shared modular multiplier: msb-first double-and-add, one multiplier bit per cycle
`default_nettype none
module mrr_modmul #(
  parameter int BITS = mrr_pkg::BITS_DEF,
  parameter int OPW  = mrr_pkg::WIT_W
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [BITS-1:0] a,
  input  wire logic [OPW-1:0]  b,
  input  wire logic [BITS-1:0] n,
  output logic                 done,
  output logic [BITS-1:0]      prod
);

  localparam int CW = (OPW > 1) ? $clog2(OPW) : 1;

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [BITS-1:0] acc;
  logic [BITS-1:0] a_r;
  logic [BITS-1:0] n_r;
  logic [OPW-1:0]  b_r;

  logic [BITS+1:0] sum;
  logic [BITS+1:0] n1;
  logic [BITS+1:0] n2;
  logic [BITS-1:0] acc_next;

  // acc < n and a < n keep the sum below 3n
  always_comb begin
    n1  = {2'b00, n_r};
    n2  = {1'b0, n_r, 1'b0};
    sum = {1'b0, acc, 1'b0} + (b_r[OPW-1] ? {2'b00, a_r} : '0);
    if (sum >= n2) begin
      acc_next = BITS'(sum - n2);
    end else if (sum >= n1) begin
      acc_next = BITS'(sum - n1);
    end else begin
      acc_next = BITS'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
      n_r <= n;
      cnt <= CW'(OPW - 1);
    end else if (busy) begin
      acc <= acc_next;
      b_r <= {b_r[OPW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign prod = acc;

endmodule
`default_nettype wire

// File: src/miller_rabin_round_top.sv
// miller-rabin round: trivial checks, n-1 split, modular power and squaring chain
//
//  channel  dir  handshake        payload
//  s_*      in   tvalid/tready    tdata[31:0] candidate, tdata[63:32] witness
//  m_*      out  tvalid/tready    tdata[0] probable_prime, tuser decided_trivially
//
// trivial candidates go from idle straight to the finish state and the output register.
// others: the n-1 split strips k factors of two, then each modular product on the shared
// multiplier runs over OPW multiplier bits (OPW = max(BITS,32)); one reduction, up to 2*BITS products
// for the power and up to k-1 squarings.
// synchronous reset clears the sequencer and the output valid.
// s_tready is high only in idle; a held result blocks only the next completion.
`default_nettype none
module miller_rabin_round_top #(
  parameter int BITS = mrr_pkg::BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [mrr_pkg::IN_W-1:0]   s_tdata,   // candidate, witness
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [mrr_pkg::OUT_W-1:0]       m_tdata,   // probable_prime, zero fill
  output logic                            m_tuser    // decided_trivially
);

  localparam int OPW = (BITS > mrr_pkg::WIT_W) ? BITS : mrr_pkg::WIT_W;
  localparam int KW  = $clog2(BITS);

  mrr_pkg::state_t state, state_next;

  logic [BITS-1:0]          n_reg;
  logic [BITS-1:0]          nm1;
  logic [mrr_pkg::WIT_W-1:0] w_reg;
  logic [BITS-1:0]          e;
  logic [KW-1:0]            k;
  logic [KW-1:0]            sq_left;
  logic [BITS-1:0]          r;
  logic [BITS-1:0]          base;
  logic                     res_prime;
  logic                     res_triv;

  logic [BITS-1:0] n_in;
  logic            in_acc;
  logic            trivial;
  logic            triv_prime;
  logic            out_free;

  logic            mul_start;
  logic [BITS-1:0] mul_a;
  logic [OPW-1:0]  mul_b;
  logic            mul_done;
  logic [BITS-1:0] mul_prod;

  assign n_in       = BITS'(s_tdata[mrr_pkg::CAND_W-1:0]);
  assign in_acc     = s_tvalid && s_tready;
  // below two, two, three, or even
  assign triv_prime = (n_in[BITS-1:2] == '0) && n_in[1];
  assign trivial    = (n_in[BITS-1:2] == '0) || !n_in[0];
  assign out_free   = !m_tvalid || m_tready;

  mrr_modmul #(
    .BITS (BITS),
    .OPW  (OPW)
  ) u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .n     (n_reg),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mrr_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = trivial ? mrr_pkg::S_FIN : mrr_pkg::S_STRIP;
        end
      end
      mrr_pkg::S_STRIP: begin
        if (e[0]) begin
          state_next = mrr_pkg::S_RED_GO;
        end
      end
      mrr_pkg::S_RED_GO:   state_next = mrr_pkg::S_RED_WAIT;
      mrr_pkg::S_RED_WAIT: begin
        if (mul_done) begin
          state_next = mrr_pkg::S_POW_CHK;
        end
      end
      mrr_pkg::S_POW_CHK: begin
        if (e == '0) begin
          state_next = mrr_pkg::S_CHECK;
        end else if (e[0]) begin
          state_next = mrr_pkg::S_PMUL_GO;
        end else begin
          state_next = mrr_pkg::S_PSQ_GO;
        end
      end
      mrr_pkg::S_PMUL_GO:   state_next = mrr_pkg::S_PMUL_WAIT;
      mrr_pkg::S_PMUL_WAIT: begin
        if (mul_done) begin
          state_next = mrr_pkg::S_PSQ_GO;
        end
      end
      mrr_pkg::S_PSQ_GO:   state_next = mrr_pkg::S_PSQ_WAIT;
      mrr_pkg::S_PSQ_WAIT: begin
        if (mul_done) begin
          state_next = mrr_pkg::S_POW_CHK;
        end
      end
      mrr_pkg::S_CHECK: begin
        if (r == BITS'(1) || r == nm1) begin
          state_next = mrr_pkg::S_FIN;
        end else begin
          state_next = mrr_pkg::S_SQ_CHK;
        end
      end
      mrr_pkg::S_SQ_CHK: begin
        state_next = (sq_left == '0) ? mrr_pkg::S_FIN : mrr_pkg::S_SQ_GO;
      end
      mrr_pkg::S_SQ_GO:   state_next = mrr_pkg::S_SQ_WAIT;
      mrr_pkg::S_SQ_WAIT: begin
        if (mul_done) begin
          state_next = (mul_prod == nm1) ? mrr_pkg::S_FIN : mrr_pkg::S_SQ_CHK;
        end
      end
      mrr_pkg::S_FIN: begin
        if (out_free) begin
          state_next = mrr_pkg::S_IDLE;
        end
      end
      default: state_next = mrr_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: request side and multiplier operands
  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    mul_a     = base;
    mul_b     = OPW'(base);
    case (state)
      mrr_pkg::S_IDLE: s_tready = 1'b1;
      mrr_pkg::S_RED_GO: begin
        // witness mod n as witness * 1
        mul_start = 1'b1;
        mul_a     = BITS'(1);
        mul_b     = OPW'(w_reg);
      end
      mrr_pkg::S_PMUL_GO: begin
        mul_start = 1'b1;
        mul_a     = r;
        mul_b     = OPW'(base);
      end
      mrr_pkg::S_PSQ_GO: begin
        mul_start = 1'b1;
        mul_a     = base;
        mul_b     = OPW'(base);
      end
      mrr_pkg::S_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = r;
        mul_b     = OPW'(r);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mrr_pkg::S_IDLE: begin
        if (in_acc) begin
          n_reg     <= n_in;
          nm1       <= n_in - 1'b1;
          e         <= n_in - 1'b1;
          w_reg     <= s_tdata[mrr_pkg::CAND_W +: mrr_pkg::WIT_W];
          k         <= '0;
          res_prime <= triv_prime;
          res_triv  <= trivial;
        end
      end
      mrr_pkg::S_STRIP: begin
        if (!e[0]) begin
          e <= e >> 1;
          k <= k + 1'b1;
        end
      end
      mrr_pkg::S_RED_WAIT: begin
        if (mul_done) begin
          base <= mul_prod;
          r    <= BITS'(1);
        end
      end
      mrr_pkg::S_PMUL_WAIT: begin
        if (mul_done) begin
          r <= mul_prod;
        end
      end
      mrr_pkg::S_PSQ_WAIT: begin
        if (mul_done) begin
          base <= mul_prod;
          e    <= e >> 1;
        end
      end
      mrr_pkg::S_CHECK: begin
        res_prime <= (r == BITS'(1)) || (r == nm1);
        sq_left   <= k - 1'b1;
      end
      mrr_pkg::S_SQ_WAIT: begin
        if (mul_done) begin
          r         <= mul_prod;
          sq_left   <= sq_left - 1'b1;
          res_prime <= (mul_prod == nm1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == mrr_pkg::S_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mrr_pkg::S_FIN && out_free) begin
      m_tdata <= mrr_pkg::OUT_W'(res_prime);
      m_tuser <= res_triv;
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != mrr_pkg::S_IDLE)
    else $error("accepted request did not start work");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == mrr_pkg::S_RED_WAIT || state == mrr_pkg::S_PMUL_WAIT ||
                  state == mrr_pkg::S_PSQ_WAIT || state == mrr_pkg::S_SQ_WAIT))
    else $error("multiplier finished outside a wait state");

  a_strip_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == mrr_pkg::S_STRIP |-> e != '0)
    else $error("n-1 split ran on zero");

  a_triv_prime_small: assert property (@(posedge clk) disable iff (rst)
    (state == mrr_pkg::S_FIN && res_triv && res_prime) |-> n_reg[BITS-1:2] == '0)
    else $error("trivial prime verdict for large n");
`endif

endmodule
`default_nettype wire

// File: dv/tb_miller_rabin_round_top.sv
// testbench for miller_rabin_round_top: directed and random rounds checked against a predictor
module tb_miller_rabin_round_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BITS        = mrr_pkg::BITS_DEF;
  localparam int N_DIRECTED  = 25;
  localparam int N_RANDOM    = 115;
  localparam int HOLD_AFTER  = 30;     // result count at which the sink holds off
  localparam int LONG_HOLD   = 10000;  // cycles, well past one full round
  localparam logic [63:0] NMASK = (64'd1 << BITS) - 64'd1;

  typedef struct packed {
    logic probable_prime;
    logic decided_trivially;
  } verdict_t;

  typedef struct {
    logic [31:0] cand;
    logic [31:0] wit;
    bit          hold_for_drain;
  } round_req_t;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic [mrr_pkg::IN_W-1:0]  s_tdata  = '0;
  logic                      m_tready = 1'b0;
  logic                      s_tready;
  logic                      m_tvalid;
  logic [mrr_pkg::OUT_W-1:0] m_tdata;
  logic                      m_tuser;

  round_req_t rounds_todo[$];
  verdict_t   verdicts_due[$];

  bit req_taken = 1'b0;
  bit rsp_taken = 1'b0;
  bit tx_quiet  = 1'b0;
  bit rx_quiet  = 1'b0;
  int tx_gap    = 0;
  int rx_wait   = 0;
  int got_cnt   = 0;
  int errors    = 0;

  miller_rabin_round_top #(.BITS(BITS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // n stays below 2^32, so a full product fits in 64 bits
  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [63:0] p;
    p = a * b;
    return p % n;
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] n);
    logic [63:0] r;
    r = 64'd1 % n;
    base = base % n;
    while (e != 0) begin
      if (e[0]) r = mulmod(r, base, n);
      base = mulmod(base, base, n);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic verdict_t mr_round(logic [31:0] cand, logic [31:0] wit);
    verdict_t    v;
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] b;
    int          twos;
    n = {32'd0, cand} & NMASK;
    v.decided_trivially = 1'b1;
    v.probable_prime    = 1'b0;
    if (n < 2) return v;
    if (n < 4) begin
      v.probable_prime = 1'b1;
      return v;
    end
    if (!n[0]) return v;
    v.decided_trivially = 1'b0;
    m = n - 1;
    twos = 0;
    while (!m[0]) begin
      m = m >> 1;
      twos++;
    end
    b = powmod({32'd0, wit} % n, m, n);
    if (b == 1 || b == n - 1) begin
      v.probable_prime = 1'b1;
    end else begin
      for (int j = 1; j < twos && !v.probable_prime; j++) begin
        b = mulmod(b, b, n);
        if (b == n - 1) v.probable_prime = 1'b1;
      end
    end
    return v;
  endfunction

  // bases 2..11 settle primality for every 32-bit n
  function automatic bit is_prime(logic [63:0] n);
    int unsigned bases[5] = '{2, 3, 5, 7, 11};
    verdict_t    v;
    if (n < 2) return 1'b0;
    foreach (bases[i]) begin
      if (bases[i] % n == 0) continue;
      v = mr_round(n[31:0], bases[i]);
      if (!v.probable_prime) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] prime_near(logic [31:0] start);
    logic [63:0] n;
    n = {32'd0, start} | 64'd1;
    if (n < 5) n = 5;
    while (!is_prime(n)) begin
      n = n + 2;
      if (n >= 64'h1_0000_0000) n = 5;
    end
    return n[31:0];
  endfunction

  // prime of the form m*2^k+1, so the squaring chain runs long
  function automatic logic [31:0] prime_with_twos(int k);
    logic [63:0] m;
    logic [63:0] n;
    m = ({32'd0, $urandom} >> (k + 1)) | 64'd1;
    n = (m << k) + 1;
    while (!is_prime(n)) begin
      m = m + 2;
      n = (m << k) + 1;
      if (n >= 64'h1_0000_0000) begin
        m = 1;
        n = (m << k) + 1;
      end
    end
    return n[31:0];
  endfunction

  task automatic add_round(logic [31:0] cand, logic [31:0] wit, bit drain);
    round_req_t r;
    r.cand = cand;
    r.wit = wit;
    r.hold_for_drain = drain;
    rounds_todo.push_back(r);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    logic        nxt_valid;
    logic [63:0] nxt_data;
    round_req_t  r;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (req_taken) begin
        nxt_valid = 1'b0;
        tx_gap = tx_quiet ? 0 : $urandom_range(18, 0);
        if ($urandom_range(7, 0) == 0) tx_quiet = !tx_quiet;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (rounds_todo.size() != 0 &&
                     !(rounds_todo[0].hold_for_drain && verdicts_due.size() != 0)) begin
          r = rounds_todo.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = {r.wit, r.cand};
        end
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= nxt_data;
  end

  // result sink with random stalls and one long hold-off
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (!rst) begin
      if (rsp_taken) begin
        rx_wait = rx_quiet ? 0 : $urandom_range(18, 0);
        if (got_cnt == HOLD_AFTER) rx_wait = LONG_HOLD;
        if ($urandom_range(7, 0) == 0) rx_quiet = !rx_quiet;
      end
      if (rx_wait > 0) begin
        rx_wait--;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    m_tready <= nxt_ready;
  end

  // monitor: predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    verdict_t want;
    req_taken <= !rst && s_tvalid && s_tready;
    rsp_taken <= !rst && m_tvalid && m_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        verdicts_due.push_back(mr_round(s_tdata[31:0], s_tdata[63:32]));
      end
      if (m_tvalid && m_tready) begin
        got_cnt <= got_cnt + 1;
        if (verdicts_due.size() == 0) begin
          $error("unexpected result: probable_prime %0b, decided_trivially %0b",
                 m_tdata[0], m_tuser);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (m_tdata[0] !== want.probable_prime) begin
            $error("probable_prime: expected %0b, got %0b", want.probable_prime, m_tdata[0]);
            errors++;
          end
          if (m_tuser !== want.decided_trivially) begin
            $error("decided_trivially: expected %0b, got %0b",
                   want.decided_trivially, m_tuser);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] w;

    // trivial verdicts
    add_round(32'd0, 32'd0, 1'b0);
    add_round(32'd1, 32'hFFFF_FFFF, 1'b0);
    add_round(32'd2, 32'd0, 1'b0);
    add_round(32'd3, 32'hFFFF_FFFF, 1'b0);
    add_round(32'd4, 32'd3, 1'b0);
    add_round(32'hFFFF_FFFE, 32'd7, 1'b0);
    // largest odd and largest prime, witness reduced, zero, one and n-1
    add_round(32'hFFFF_FFFF, 32'd2, 1'b0);
    add_round(32'hFFFF_FFFB, 32'd2, 1'b0);
    add_round(32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b0);
    add_round(32'hFFFF_FFFB, 32'hFFFF_FFFB, 1'b0);
    add_round(32'hFFFF_FFFB, 32'hFFFF_FFFA, 1'b0);
    add_round(32'hFFFF_FFFB, 32'd1, 1'b0);
    add_round(32'd5, 32'd0, 1'b0);
    add_round(32'd5, 32'd1, 1'b0);
    add_round(32'd5, 32'd4, 1'b0);
    add_round(32'd5, 32'd10, 1'b0);
    // strong pseudoprimes, carmichael, long squaring chains
    add_round(32'd2047, 32'd2, 1'b0);
    add_round(32'd3215031751, 32'd2, 1'b0);
    add_round(32'd561, 32'd2, 1'b0);
    add_round(32'd65537, 32'd3, 1'b0);
    add_round(32'd3221225473, 32'd5, 1'b0);
    add_round(32'd2147483649, 32'd2, 1'b0);
    add_round(32'd9, 32'd8, 1'b0);
    add_round(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    add_round(32'hAAAA_AAAB, 32'h5555_5555, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      bit drain;
      drain = (i == 0) || (i == 65);
      case ($urandom_range(9, 0))
        0, 1, 2: add_round($urandom, $urandom, drain);
        3, 4: add_round(prime_near($urandom), $urandom, drain);
        5: add_round($urandom_range(40, 0), $urandom_range(50, 0), drain);
        6: begin
          p = prime_near($urandom);
          case ($urandom_range(5, 0))
            0: w = 32'd0;
            1: w = 32'd1;
            2: w = p - 1;
            3: w = p;
            4: w = p + 1;
            default: w = p << 1;
          endcase
          add_round(p, w, drain);
        end
        7: begin
          p = prime_near($urandom_range(65535, 3));
          q = prime_near($urandom_range(65535, 3));
          add_round(p * q, $urandom, drain);
        end
        // 15*2^27+1 is prime, so every k up to 27 has a 32-bit prime
        8: add_round(prime_with_twos($urandom_range(27, 8)), $urandom, drain);
        default: begin
          p = $urandom | 32'd1;
          case ($urandom_range(3, 0))
            0: w = 32'd0;
            1: w = 32'd1;
            2: w = p - 1;
            default: w = 32'hFFFF_FFFF;
          endcase
          add_round(p, w, drain);
        end
      endcase
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (rounds_todo.size() != 0 || s_tvalid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
